// ===== design/bssr_pkg.sv =====
// Package for the byte stack core: command and fault codes, the control word
// layout and the microprogram table. No dependencies.
`timescale 1ns / 1ps

package bssr_pkg;

  localparam int BSSR_DEPTH = 64;

  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int FAULT_W = 2;
  localparam int UPC_W   = 4;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_FULL  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd2;

  typedef logic [UPC_W-1:0] upc_t;

  // Step addresses of the microprogram.
  localparam upc_t UPC_IDLE      = 4'd0;
  localparam upc_t UPC_PUSH      = 4'd1;
  localparam upc_t UPC_POP       = 4'd2;
  localparam upc_t UPC_CLEAR     = 4'd3;
  localparam upc_t UPC_REM_SCAN  = 4'd4;
  localparam upc_t UPC_REM_SET   = 4'd5;
  localparam upc_t UPC_SRCH_SCAN = 4'd6;
  localparam upc_t UPC_TOP_READ  = 4'd7;
  localparam upc_t UPC_RESULT    = 4'd8;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP,
    ACT_CLEAR,
    ACT_SCAN,
    ACT_SCAN_REMOVE,
    ACT_SET_LEVEL,
    ACT_TOP_READ,
    ACT_RESULT
  } act_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_MORE,
    J_DISPATCH
  } jump_t;

  typedef struct packed {
    act_t  act;
    jump_t jump;
    upc_t  target;
  } uword_t;

  // The microprogram. J_MORE loops to the target while entries remain to be read.
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    begin
      case (addr)
        UPC_IDLE:      w = '{act: ACT_NONE,        jump: J_DISPATCH, target: UPC_IDLE};
        UPC_PUSH:      w = '{act: ACT_PUSH,        jump: J_ALWAYS,   target: UPC_TOP_READ};
        UPC_POP:       w = '{act: ACT_POP,         jump: J_ALWAYS,   target: UPC_TOP_READ};
        UPC_CLEAR:     w = '{act: ACT_CLEAR,       jump: J_ALWAYS,   target: UPC_TOP_READ};
        UPC_REM_SCAN:  w = '{act: ACT_SCAN_REMOVE, jump: J_MORE,     target: UPC_REM_SCAN};
        UPC_REM_SET:   w = '{act: ACT_SET_LEVEL,   jump: J_ALWAYS,   target: UPC_TOP_READ};
        UPC_SRCH_SCAN: w = '{act: ACT_SCAN,        jump: J_MORE,     target: UPC_SRCH_SCAN};
        UPC_TOP_READ:  w = '{act: ACT_TOP_READ,    jump: J_NEXT,     target: UPC_IDLE};
        UPC_RESULT:    w = '{act: ACT_RESULT,      jump: J_ALWAYS,   target: UPC_IDLE};
        default:       w = '{act: ACT_NONE,        jump: J_ALWAYS,   target: UPC_IDLE};
      endcase
      return w;
    end
  endfunction

  // Entry step for each command; unused codes go straight to the top read.
  function automatic upc_t dispatch(input logic [CMD_W-1:0] cmd);
    upc_t a;
    begin
      case (cmd)
        CMD_PUSH:   a = UPC_PUSH;
        CMD_POP:    a = UPC_POP;
        CMD_CLEAR:  a = UPC_CLEAR;
        CMD_SEARCH: a = UPC_SRCH_SCAN;
        CMD_REMOVE: a = UPC_REM_SCAN;
        default:    a = UPC_TOP_READ;
      endcase
      return a;
    end
  endfunction

endpackage

// ===== design/bssr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/byte_stack_search_remove_core.sv =====
// Top level of the byte stack with search and remove: a microcoded sequencer
// driving a small datapath around one stack RAM. Uses bssr_pkg and bssr_ram.
`timescale 1ns / 1ps

// Channel    | Signals                                   | Transaction
// -----------+-------------------------------------------+--------------------------------
// command in | start, busy, cmd[2:0], value[7:0]         | start high while busy is low
// result out | done, found, top_entry[7:0],              | done high for one cycle, always
//            | entry_count[6:0], is_empty, fault[1:0]    | taken
//
// Push, pop and clear run their action step, the top read and the result step, which
// raises done; unused codes skip to the top read. Search runs the scan loop, which
// reads one stack entry per cycle through the RAM's single read port, before the top
// read and result; remove also sets the new level between the scan and the top read.
// A new command can be accepted in the cycle after done.
// Synchronous reset empties the stack and returns the sequencer to idle; the RAM
// itself is not cleared, since only entries below the fill level are ever used.
// The receiver cannot stall: each result is shown for exactly one cycle.

module byte_stack_search_remove_core #(
  parameter int DEPTH = bssr_pkg::BSSR_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bssr_pkg::CMD_W-1:0]    cmd,
  input  logic [bssr_pkg::BYTE_W-1:0]   value,
  output logic                          done,
  output logic                          found,
  output logic [bssr_pkg::BYTE_W-1:0]   top_entry,
  output logic [bssr_pkg::COUNT_W-1:0]  entry_count,
  output logic                          is_empty,
  output logic [bssr_pkg::FAULT_W-1:0]  fault
);

  import bssr_pkg::*;

  // Address width of the store, and level width able to hold DEPTH itself.
  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  // Sequencer state.
  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;

  // Datapath registers.
  logic [CMD_W-1:0]   cmd_q,   cmd_next;
  logic [BYTE_W-1:0]  value_q, value_next;
  logic [LW-1:0]      level,   level_next;
  logic [LW-1:0]      rd,      rd_next;
  logic [LW-1:0]      wr,      wr_next;
  logic               pend,    pend_next;
  logic               found_q, found_next;
  logic [FAULT_W-1:0] fault_q, fault_next;

  // Store port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic          accept;
  logic          more;
  logic [LW-1:0] level_dec;

  assign uw        = ucode(upc);
  assign busy      = (upc != UPC_IDLE);
  assign accept    = start && !busy;
  assign more      = (rd < level);
  assign level_dec = level - 1'b1;

  bssr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next step: fall through, jump, loop while entries remain, or dispatch on
  // the command code when a transaction is accepted.
  always_comb begin
    case (uw.jump)
      J_NEXT:     upc_next = upc + 1'b1;
      J_ALWAYS:   upc_next = uw.target;
      J_MORE:     upc_next = more ? uw.target : upc + 1'b1;
      J_DISPATCH: upc_next = accept ? dispatch(cmd) : upc;
      default:    upc_next = UPC_IDLE;
    endcase
  end

  // Datapath control decoded from the current control word.
  always_comb begin
    cmd_next   = cmd_q;
    value_next = value_q;
    level_next = level;
    rd_next    = rd;
    wr_next    = wr;
    pend_next  = pend;
    found_next = found_q;
    fault_next = fault_q;
    ram_we     = 1'b0;
    ram_waddr  = level[AW-1:0];
    ram_wdata  = value_q;
    ram_raddr  = rd[AW-1:0];
    done       = 1'b0;

    if (accept) begin
      cmd_next   = cmd;
      value_next = value;
      rd_next    = '0;
      wr_next    = '0;
      pend_next  = 1'b0;
      found_next = 1'b0;
      fault_next = FAULT_NONE;
    end

    case (uw.act)
      ACT_PUSH: begin
        if (level == LW'(DEPTH)) begin
          fault_next = FAULT_FULL;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = level[AW-1:0];
          ram_wdata  = value_q;
          level_next = level + 1'b1;
        end
      end
      ACT_POP: begin
        if (level == '0) begin
          fault_next = FAULT_EMPTY;
        end else begin
          level_next = level_dec;
        end
      end
      ACT_CLEAR: begin
        level_next = '0;
      end
      ACT_SCAN, ACT_SCAN_REMOVE: begin
        // Issue the read of entry rd while comparing the entry read last cycle.
        ram_raddr = rd[AW-1:0];
        pend_next = more;
        if (more) begin
          rd_next = rd + 1'b1;
        end
        if (pend) begin
          if (ram_rdata == value_q) begin
            found_next = 1'b1;
          end else if (uw.act == ACT_SCAN_REMOVE) begin
            // Compact the survivors downwards; wr always trails rd.
            ram_we    = 1'b1;
            ram_waddr = wr[AW-1:0];
            ram_wdata = ram_rdata;
            wr_next   = wr + 1'b1;
          end
        end
      end
      ACT_SET_LEVEL: begin
        level_next = wr;
      end
      ACT_TOP_READ: begin
        ram_raddr = level_dec[AW-1:0];
      end
      ACT_RESULT: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc   <= UPC_IDLE;
      level <= '0;
      pend  <= 1'b0;
    end else begin
      upc   <= upc_next;
      level <= level_next;
      pend  <= pend_next;
    end
    cmd_q   <= cmd_next;
    value_q <= value_next;
    rd      <= rd_next;
    wr      <= wr_next;
    found_q <= found_next;
    fault_q <= fault_next;
  end

  // The top entry comes from the read issued in the step before the result.
  assign found       = found_q;
  assign fault       = fault_q;
  assign entry_count = COUNT_W'(level);
  assign is_empty    = (level == '0);
  assign top_entry   = is_empty ? '0 : ram_rdata;

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("sequencer did not leave idle after an accepted transaction");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("sequencer not idle after the result strobe");

  a_full_fault : assert property (@(posedge clk) disable iff (rst)
    (done && fault_q == FAULT_FULL) |-> (level == LW'(DEPTH)))
    else $error("full fault reported while the stack is not full");

  a_found_cmd : assert property (@(posedge clk) disable iff (rst)
    (done && found_q) |-> (cmd_q == CMD_SEARCH || cmd_q == CMD_REMOVE))
    else $error("found reported for a command that does not search");

  a_compact_order : assert property (@(posedge clk) disable iff (rst)
    (uw.act == ACT_SCAN_REMOVE && ram_we) |-> (wr < rd))
    else $error("remove wrote at or above the read pointer");

endmodule
